FILE: sv/edfq_pkg.sv
// ----------------------------------------------------------------------------
// edfq_pkg
// Shared types and constants of the earliest-deadline-first ready queue.
// ----------------------------------------------------------------------------
package edfq_pkg;

   localparam int MAX_TASKS_DEF = 32;
   localparam int ID_W          = 5;
   localparam int DL_W          = 64;
   localparam int CNT_OUT_W     = 6;
   localparam int SLOTS_DEF     = 2 ** ID_W;

   typedef enum logic [1:0] {
      FUNC_REGISTER,
      FUNC_ENQUEUE,
      FUNC_DEQUEUE,
      FUNC_QUERY
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK           = 3'd0,
      STAT_UNREG        = 3'd1,
      STAT_QUEUED       = 3'd2,
      STAT_NOT_QUEUED   = 3'd3,
      STAT_CURR_UNKNOWN = 3'd4
   } status_type;

   // one queue slot
   typedef struct packed {
      logic            valid;
      logic [DL_W-1:0] deadline;
      logic [ID_W-1:0] task_id;
   } entry_type;

   // command broadcast along the cell chain
   typedef struct packed {
      logic            ins;
      logic            rem;
      logic [ID_W-1:0] task_id;
      logic [DL_W-1:0] deadline;
   } chain_cmd_type;

   // task table update
   typedef struct packed {
      logic            set_reg;
      logic            clr_reg;
      logic            set_q;
      logic            clr_q;
      logic            dl_we;
      logic [ID_W-1:0] task_id;
      logic [DL_W-1:0] deadline;
   } table_wr_type;

   // task table lookups
   typedef struct packed {
      logic            in_range;
      logic            reg_id;
      logic            queued_id;
      logic            reg_curr;
      logic [DL_W-1:0] dl_curr;
   } table_rd_type;

endpackage

FILE: sv/edf_ready_queue.sv
// ----------------------------------------------------------------------------
// edf_ready_queue
// Earliest-deadline-first ready queue built from a sorted row of cells.
// ----------------------------------------------------------------------------
// Each request carries one operation (register, enqueue, dequeue, query) and
// gets exactly one response, in order. A request is taken into an operation
// register, the absolute deadline (now plus relative, modulo 2^64) being
// formed on the way in; from there the operation executes against the
// task table and the cell row and its response is loaded into the output
// register. The operation register stays busy until the operation executes,
// so requests are not overlapped; a new request is taken while a response
// still waits, but the operation waits for the output slot.
// The queue is a row of one cell per task slot, each holding a deadline and
// task id in sorted order; insertion and removal shift the row by one place,
// all cells at once. The response shows the queue head and count after the
// operation. Erroneous requests leave all state untouched.
module edf_ready_queue import edfq_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [ID_W-1:0]      req_task_id,
   input  logic [DL_W-1:0]      req_now_time,
   input  logic [DL_W-1:0]      req_rel_deadline,
   input  logic                 req_retire,
   input  logic                 req_curr_in_class,
   input  logic [ID_W-1:0]      req_curr_id,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic                 rsp_earliest_valid,
   output logic [ID_W-1:0]      rsp_earliest_id,
   output logic [DL_W-1:0]      rsp_earliest_deadline,
   output logic                 rsp_resched,
   output logic [CNT_OUT_W-1:0] rsp_ready_count
);

   // ids are only ID_W bits wide, so no more slots than that are reachable
   localparam int NUM_SLOTS = (MAX_TASKS < SLOTS_DEF) ? MAX_TASKS : SLOTS_DEF;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   // operation register
   logic            op_valid_ff;
   logic            op_valid_in;
   func_type        op_func_ff;
   logic [ID_W-1:0] op_id_ff;
   logic [DL_W-1:0] op_dl_ff;
   logic            op_dead_ff;
   logic            op_class_ff;
   logic [ID_W-1:0] op_curr_ff;

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           status_ff;
   logic                 ev_ff;
   logic [ID_W-1:0]      eid_ff;
   logic [DL_W-1:0]      edl_ff;
   logic                 resched_ff;
   logic [CNT_OUT_W-1:0] count_ff;

   logic             req_take;
   logic             exec;
   status_type       status;
   logic             resched;
   logic             ok;
   table_rd_type     tbl_rd;
   table_wr_type     tbl_wr;
   chain_cmd_type    cmd;
   entry_type        head;
   entry_type        head_nxt;
   logic [CNT_W-1:0] count_nxt;

   // one operation in flight; stall holds while it is pending
   assign req_stall = op_valid_ff;
   assign req_take  = req_valid && !op_valid_ff;
   // execute once the output slot is free or being emptied
   assign exec      = op_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      op_valid_in = op_valid_ff;
      if (exec)     op_valid_in = 1'b0;
      if (req_take) op_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= op_valid_in;
      end
   end

   // payload of the request, absolute deadline precomputed
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_func_ff  <= func_type'(req_func);
         op_id_ff    <= req_task_id;
         op_dl_ff    <= req_now_time + req_rel_deadline;
         op_dead_ff  <= req_retire;
         op_class_ff <= req_curr_in_class;
         op_curr_ff  <= req_curr_id;
      end
   end

   edfq_task_table #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .id_i   (op_id_ff),
      .curr_i (op_curr_ff),
      .wr     (tbl_wr),
      .rd     (tbl_rd)
   );

   edfq_chain #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .head_o      (head),
      .head_nxt_o  (head_nxt),
      .count_nxt_o (count_nxt)
   );

   // status and preemption decision
   always_comb begin
      status  = STAT_OK;
      resched = 1'b0;
      case (op_func_ff)
         FUNC_REGISTER: begin
            if (!tbl_rd.in_range) begin
               status = STAT_UNREG;
            end else if (tbl_rd.queued_id) begin
               status = STAT_QUEUED;
            end
         end
         FUNC_ENQUEUE: begin
            if (!tbl_rd.reg_id) begin
               status = STAT_UNREG;
            end else if (tbl_rd.queued_id) begin
               status = STAT_QUEUED;
            end
         end
         FUNC_DEQUEUE: begin
            if (!tbl_rd.reg_id) begin
               status = STAT_UNREG;
            end else if (!tbl_rd.queued_id) begin
               status = STAT_NOT_QUEUED;
            end
         end
         FUNC_QUERY: begin
            // running task outside the class is always preempted
            if (!op_class_ff) begin
               resched = 1'b1;
            end else if (head.valid) begin
               if (!tbl_rd.reg_curr) begin
                  status = STAT_CURR_UNKNOWN;
               end else if (head.deadline < tbl_rd.dl_curr) begin
                  resched = 1'b1;
               end
            end
         end
         default: begin
            status = STAT_OK;
         end
      endcase
   end

   assign ok = exec && (status == STAT_OK);

   // state updates, only for error-free operations
   always_comb begin
      tbl_wr          = '0;
      tbl_wr.task_id  = op_id_ff;
      tbl_wr.deadline = op_dl_ff;
      cmd             = '0;
      cmd.task_id     = op_id_ff;
      cmd.deadline    = op_dl_ff;
      if (ok) begin
         case (op_func_ff)
            FUNC_REGISTER: begin
               tbl_wr.set_reg  = 1'b1;
               tbl_wr.dl_we    = 1'b1;
               tbl_wr.deadline = '0;
            end
            FUNC_ENQUEUE: begin
               tbl_wr.set_q = 1'b1;
               tbl_wr.dl_we = 1'b1;
               cmd.ins      = 1'b1;
            end
            FUNC_DEQUEUE: begin
               tbl_wr.clr_q   = 1'b1;
               tbl_wr.clr_reg = op_dead_ff;
               cmd.rem        = 1'b1;
            end
            default: begin
               cmd.ins = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (exec)                       rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response shows the queue after the operation; empty head reads as zero
   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff  <= status;
         ev_ff      <= head_nxt.valid;
         eid_ff     <= head_nxt.valid ? head_nxt.task_id : '0;
         edl_ff     <= head_nxt.valid ? head_nxt.deadline : '0;
         resched_ff <= resched;
         count_ff   <= CNT_OUT_W'(count_nxt);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_earliest_valid    = ev_ff;
   assign rsp_earliest_id       = eid_ff;
   assign rsp_earliest_deadline = edl_ff;
   assign rsp_resched           = resched_ff;
   assign rsp_ready_count       = count_ff;

endmodule

FILE: sv/edfq_cell.sv
// ----------------------------------------------------------------------------
// edfq_cell
// One slot of the sorted queue: keeps, takes the new entry or shifts.
// ----------------------------------------------------------------------------
module edfq_cell import edfq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   input  entry_type     left_i,
   input  logic          left_keep_i,
   input  logic          left_hit_i,
   input  entry_type     right_i,
   output entry_type     data_o,
   output logic          keep_o,
   output logic          hit_o
);

   entry_type data_ff;
   entry_type data_in;

   // stays in place on insert: equal deadlines stay ahead of the new one
   assign keep_o = data_ff.valid && (data_ff.deadline <= cmd.deadline);
   // this slot or one to its left holds the task being removed
   assign hit_o  = left_hit_i || (data_ff.valid && (data_ff.task_id == cmd.task_id));
   assign data_o = data_ff;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (!keep_o) begin
            if (left_keep_i) begin
               data_in.valid    = 1'b1;
               data_in.deadline = cmd.deadline;
               data_in.task_id  = cmd.task_id;
            end else begin
               data_in = left_i;
            end
         end
      end else if (cmd.rem && hit_o) begin
         data_in = right_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: sv/edfq_chain.sv
// ----------------------------------------------------------------------------
// edfq_chain
// Row of queue cells kept in deadline order, with the fill count.
// ----------------------------------------------------------------------------
module edfq_chain import edfq_pkg::*; #(
   parameter int NUM_SLOTS = SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  chain_cmd_type                    cmd,
   output entry_type                        head_o,
   output entry_type                        head_nxt_o,
   output logic [$clog2(NUM_SLOTS+1)-1:0]   count_nxt_o
);

   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   entry_type              data [NUM_SLOTS];
   entry_type              left [NUM_SLOTS];
   entry_type              right [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]   keep;
   logic [NUM_SLOTS-1:0]   hit;
   logic [NUM_SLOTS-1:0]   left_keep;
   logic [NUM_SLOTS-1:0]   left_hit;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left[i]      = '0;
         assign left_keep[i] = 1'b1;
         assign left_hit[i]  = 1'b0;
      end else begin : g_mid
         assign left[i]      = data[i-1];
         assign left_keep[i] = keep[i-1];
         assign left_hit[i]  = hit[i-1];
      end
      if (i == NUM_SLOTS - 1) begin : g_last
         assign right[i] = '0;
      end else begin : g_inner
         assign right[i] = data[i+1];
      end

      edfq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_i      (left[i]),
         .left_keep_i (left_keep[i]),
         .left_hit_i  (left_hit[i]),
         .right_i     (right[i]),
         .data_o      (data[i]),
         .keep_o      (keep[i]),
         .hit_o       (hit[i])
      );
   end

   assign head_o = data[0];

   // head after this cycle's update
   always_comb begin
      head_nxt_o = data[0];
      if (cmd.ins) begin
         if (!keep[0]) begin
            head_nxt_o.valid    = 1'b1;
            head_nxt_o.deadline = cmd.deadline;
            head_nxt_o.task_id  = cmd.task_id;
         end
      end else if (cmd.rem && hit[0]) begin
         head_nxt_o = data[1];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_nxt_o = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: sv/edfq_task_table.sv
// ----------------------------------------------------------------------------
// edfq_task_table
// Per-task registered and queued flags and absolute deadlines.
// ----------------------------------------------------------------------------
module edfq_task_table import edfq_pkg::*; #(
   parameter int NUM_SLOTS = SLOTS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [ID_W-1:0] id_i,
   input  logic [ID_W-1:0] curr_i,
   input  table_wr_type    wr,
   output table_rd_type    rd
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam logic [ID_W:0] SLOTS_V = (ID_W + 1)'(NUM_SLOTS);

   logic [NUM_SLOTS-1:0] registered_ff;
   logic [NUM_SLOTS-1:0] registered_in;
   logic [NUM_SLOTS-1:0] queued_ff;
   logic [NUM_SLOTS-1:0] queued_in;
   logic [DL_W-1:0]      deadline_ff [NUM_SLOTS];

   logic             id_ok;
   logic             curr_ok;
   logic [IDX_W-1:0] id_idx;
   logic [IDX_W-1:0] curr_idx;
   logic [IDX_W-1:0] wr_idx;

   assign id_ok    = {1'b0, id_i} < SLOTS_V;
   assign curr_ok  = {1'b0, curr_i} < SLOTS_V;
   assign id_idx   = id_i[IDX_W-1:0];
   assign curr_idx = curr_i[IDX_W-1:0];
   assign wr_idx   = wr.task_id[IDX_W-1:0];

   assign rd.in_range  = id_ok;
   assign rd.reg_id    = id_ok && registered_ff[id_idx];
   assign rd.queued_id = id_ok && queued_ff[id_idx];
   assign rd.reg_curr  = curr_ok && registered_ff[curr_idx];
   assign rd.dl_curr   = deadline_ff[curr_idx];

   always_comb begin
      registered_in = registered_ff;
      queued_in     = queued_ff;
      if (wr.set_reg) registered_in[wr_idx] = 1'b1;
      if (wr.clr_reg) registered_in[wr_idx] = 1'b0;
      if (wr.set_q)   queued_in[wr_idx]     = 1'b1;
      if (wr.clr_q)   queued_in[wr_idx]     = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         registered_ff <= '0;
         queued_ff     <= '0;
      end else begin
         registered_ff <= registered_in;
         queued_ff     <= queued_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.dl_we) begin
         deadline_ff[wr_idx] <= wr.deadline;
      end
   end

endmodule
